### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: modes, result status,
// sequencer states and the result word handed to the output register.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_W      = 32;
    localparam int PORT_PAY_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_DUMP     = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_LOOK,
        S_DUMP,
        S_EMIT
    } state_t;

    // One result word from the sequencer to the output register
    typedef struct packed {
        logic                   load;
        status_t                status;
        logic [KEY_W-1:0]       key;
        logic [PORT_PAY_W-1:0]  payload;
        logic                   last;
    } result_req_t;

endpackage

### hdl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted priority queue on one entry RAM (key and payload per entry), driven
// by a sequencer, with a registered stream output.
// ----------------------------------------------------------------------------
// Work per item: clear walks no entries; insert walks back over the entries
//   with a greater key, none when full; lookup walks every entry, plus the
//   insert walk when a missing key is inserted; dump walks every entry.
// Throughput: one item in flight, the next taken once the result is issued;
//   the RAM read port is walked one entry per cycle, a dump only while out_free.
// Reset clears the entry count and control state; RAM contents stay as they are.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], payload[63:32]
    input  logic [2:0]  s_tuser,   // mode[1:0], insert_if_missing[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_key[31:0], out_payload[63:32]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_W + PAYLOAD_BITS;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [EW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [EW-1:0]         ram_rd_data;
    logic                  out_free;
    result_req_t           out_req;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [KEY_W-1:0]      m_key_reg;
    logic [PORT_PAY_W-1:0] m_pay_reg;
    logic                  m_last_reg;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    spq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (mode_t'(s_tuser[1:0])),
        .in_key      (s_tdata[31:0]),
        .in_payload  (s_tdata[63:32]),
        .in_ins      (s_tuser[2]),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_free    (out_free),
        .out_req     (out_req)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_req.load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_req.load)
        begin
            m_status_reg <= out_req.status;
            m_key_reg    <= out_req.key;
            m_pay_reg    <= out_req.payload;
            m_last_reg   <= out_req.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pay_reg, m_key_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue: walks the entry RAM one entry a cycle to shift
// entries up on insert, close gaps on removal and read a dump while out_free.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input word
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mode_t                       in_mode,
    input  logic [KEY_W-1:0]            in_key,
    input  logic [PORT_PAY_W-1:0]       in_payload,
    input  logic                        in_ins,
    // entry RAM
    output logic                        ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]    ram_wr_addr,
    output logic [KEY_W+PAYLOAD_BITS-1:0] ram_wr_data,
    output logic                        ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]    ram_rd_addr,
    input  logic [KEY_W+PAYLOAD_BITS-1:0] ram_rd_data,
    // result
    input  logic                        out_free,
    output result_req_t                 out_req
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PORT_PAY_W-1:0]   pay_reg, pay_next;
    logic                    ins_reg, ins_next;
    logic                    found_reg, found_next;
    status_t                 res_status_reg, res_status_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [PORT_PAY_W-1:0]   res_pay_reg, res_pay_next;

    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    tbl_full;
    logic                    tbl_empty;
    logic [AW-1:0]           last_idx;
    logic                    at_last;
    logic                    hit;
    logic                    key_less;

    assign rd_key    = ram_rd_data[KEY_W-1:0];
    assign rd_pay    = ram_rd_data[KEY_W +: PAYLOAD_BITS];
    assign tbl_full  = (count_reg == CW'(DEPTH));
    assign tbl_empty = (count_reg == '0);
    assign last_idx  = AW'(count_reg - CW'(1));
    assign at_last   = (idx_reg == last_idx);
    assign hit       = !found_reg && (rd_key == key_reg);
    assign key_less  = ($signed(key_reg) < $signed(rd_key));

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        ins_reg        <= ins_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
    end

    // Next state, RAM control and result request
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        ins_next        = ins_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;

        in_ready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = {PAYLOAD_BITS'(pay_reg), key_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;

        out_req         = '0;
        out_req.status  = res_status_reg;
        out_req.key     = res_key_reg;
        out_req.payload = res_pay_reg;
        out_req.last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next     = in_key;
                    pay_next     = in_payload;
                    ins_next     = in_ins;
                    found_next   = 1'b0;
                    res_key_next = '0;
                    res_pay_next = '0;
                    unique case (in_mode)
                        MODE_INSERT:
                        begin
                            // unless full or empty, shift back from the tail
                            if (tbl_full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (tbl_empty)
                            begin
                                idx_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = last_idx;
                                idx_next    = last_idx;
                                state_next  = S_INS;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (tbl_empty)
                            begin
                                if (in_ins)
                                begin
                                    idx_next   = '0;
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    res_status_next = ST_NOTFOUND;
                                    state_next      = S_EMIT;
                                end
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                idx_next    = '0;
                                state_next  = S_LOOK;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = ST_CLEARED;
                            state_next      = S_EMIT;
                        end
                        MODE_DUMP:
                        begin
                            if (tbl_empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                idx_next    = '0;
                                state_next  = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                ram_wr_en = 1'b1;
                if (key_less)
                begin
                    // move the larger entry up one slot
                    ram_wr_addr = AW'(idx_reg + AW'(1));
                    ram_wr_data = ram_rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(idx_reg - AW'(1));
                        idx_next    = AW'(idx_reg - AW'(1));
                    end
                end
                else
                begin
                    // drop the new entry after this one
                    ram_wr_addr     = AW'(idx_reg + AW'(1));
                    count_next      = CW'(count_reg + CW'(1));
                    res_status_next = ST_INSERTED;
                    state_next      = S_EMIT;
                end
            end

            S_PUT:
            begin
                ram_wr_en       = 1'b1;
                count_next      = CW'(count_reg + CW'(1));
                res_status_next = ST_INSERTED;
                state_next      = S_EMIT;
            end

            S_LOOK:
            begin
                if (hit)
                begin
                    found_next   = 1'b1;
                    res_key_next = rd_key;
                    res_pay_next = PORT_PAY_W'(rd_pay);
                end
                else if (found_reg)
                begin
                    // close the gap behind the removed entry
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = AW'(idx_reg - AW'(1));
                    ram_wr_data = ram_rd_data;
                end

                if (at_last)
                begin
                    if (hit || found_reg)
                    begin
                        count_next      = CW'(count_reg - CW'(1));
                        res_status_next = ST_REMOVED;
                        state_next      = S_EMIT;
                    end
                    else if (ins_reg)
                    begin
                        // missing key: fall back to insert
                        if (tbl_full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = last_idx;
                            idx_next    = last_idx;
                            state_next  = S_INS;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(idx_reg + AW'(1));
                    idx_next    = AW'(idx_reg + AW'(1));
                end
            end

            S_DUMP:
            begin
                // hand one entry a cycle to the output register when free
                if (out_free)
                begin
                    out_req.load    = 1'b1;
                    out_req.status  = ST_DUMP;
                    out_req.key     = rd_key;
                    out_req.payload = PORT_PAY_W'(rd_pay);
                    out_req.last    = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(idx_reg + AW'(1));
                        idx_next    = AW'(idx_reg + AW'(1));
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_req.load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only dump words may leave a run open
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_DUMP) |-> m_tlast)
        else $error("non-dump result without last");

    // Key and payload are zero unless an entry is returned
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_DUMP) && (m_tuser != ST_REMOVED) |-> m_tdata == '0)
        else $error("status result carries data");

    // Busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item in progress");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

### dv/sorted_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue. A directed table covers
// the key extremes, equal-key ordering, full and empty cases, misses with and
// without the insert flag, and clears. A random phase of fill runs, drain runs
// and single operations follows. Every result word is checked against a
// shadow copy of the sorted table, with random idling on both stream sides
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RAND_ITEMS   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        status_t     st;
        logic [31:0] k;
        logic [31:0] p;
        logic        lst;
    } word_t;

    typedef struct {
        mode_t       mode;
        logic [31:0] k;
        logic [31:0] p;
        logic        ins;
        int          reps;
        bit          pin;
        word_t       pinned;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], payload[63:32]
    logic [2:0]  s_tuser;   // mode[1:0], insert_if_missing[2]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // out_key[31:0], out_payload[63:32]
    logic [2:0]  m_tuser;   // status[2:0]
    logic        m_tlast;

    // Shadow copy of the sorted table
    logic [31:0] shadow_key [DEPTH];
    logic [31:0] shadow_pay [DEPTH];
    int          shadow_count = 0;

    word_t       pending_words[$];
    plan_row_t   plan[$];

    int  err_cnt      = 0;
    int  n_items      = 0;
    int  n_results    = 0;
    int  hold_count   = 0;
    int  idle_cycles  = 0;
    int  status_seen [8];
    bit  src_idle     = 1'b1;
    bit  snk_idle     = 1'b1;
    bit  hold_req     = 1'b0;
    word_t no_pin;

    sorted_priority_queue_unit #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------
    task automatic push_word(input status_t st, input logic [31:0] k,
                             input logic [31:0] p, input logic lst);
        word_t w;
        w.st  = st;
        w.k   = k;
        w.p   = p;
        w.lst = lst;
        pending_words.push_back(w);
    endtask

    // Place after all equal keys; report full without touching the table
    task automatic shadow_insert(input logic [31:0] k, input logic [31:0] p,
                                 output status_t st);
        int pos;
        if (shadow_count >= DEPTH)
        begin
            st = ST_FULL;
        end
        else
        begin
            pos = shadow_count;
            for (int i = shadow_count - 1; i >= 0; i--)
                if ($signed(k) < $signed(shadow_key[i]))
                    pos = i;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_key[i] = shadow_key[i-1];
                shadow_pay[i] = shadow_pay[i-1];
            end
            shadow_key[pos] = k;
            shadow_pay[pos] = p;
            shadow_count++;
            st = ST_INSERTED;
        end
    endtask

    task automatic shadow_apply(input mode_t m, input logic [31:0] k,
                                input logic [31:0] p, input logic ins);
        int      hit;
        status_t st;
        hit = -1;
        case (m)
            MODE_INSERT:
            begin
                shadow_insert(k, p, st);
                push_word(st, '0, '0, 1'b1);
            end
            MODE_LOOKUP:
            begin
                // Oldest entry with the key wins
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_key[i] == k)
                        hit = i;
                if (hit >= 0)
                begin
                    push_word(ST_REMOVED, shadow_key[hit], shadow_pay[hit], 1'b1);
                    for (int j = hit; j + 1 < shadow_count; j++)
                    begin
                        shadow_key[j] = shadow_key[j+1];
                        shadow_pay[j] = shadow_pay[j+1];
                    end
                    shadow_count--;
                end
                else if (ins)
                begin
                    shadow_insert(k, p, st);
                    push_word(st, '0, '0, 1'b1);
                end
                else
                begin
                    push_word(ST_NOTFOUND, '0, '0, 1'b1);
                end
            end
            MODE_CLEAR:
            begin
                shadow_count = 0;
                push_word(ST_CLEARED, '0, '0, 1'b1);
            end
            default:
            begin
                if (shadow_count == 0)
                    push_word(ST_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < shadow_count; i++)
                    push_word(ST_DUMP, shadow_key[i], shadow_pay[i],
                              i == shadow_count - 1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side: optional gap, offer, wait for the handshake, predict
    // ------------------------------------------------------------------
    task automatic offer_word(input mode_t m, input logic [31:0] k,
                              input logic [31:0] p, input logic ins,
                              input bit pin, input word_t pinned);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {p, k};
        s_tuser  <= {ins, m};
        do @(posedge clk); while (!s_tready);
        shadow_apply(m, k, p, ins);
        if (pin)
        begin
            void'(pending_words.pop_back());
            pending_words.push_back(pinned);
        end
        n_items++;
    endtask

    // Half small keys for ties and hits, some stored keys, some full-range
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return $urandom_range(0, 16) - 8;
        if (r == 2 && shadow_count > 0)
            return shadow_key[$urandom_range(0, shadow_count - 1)];
        return $urandom;
    endfunction

    task automatic fill_run();
        while (shadow_count < DEPTH)
            offer_word(MODE_INSERT, pick_key(), $urandom, 1'($urandom_range(0, 1)),
                       1'b0, no_pin);
        offer_word(MODE_INSERT, pick_key(), $urandom, 1'($urandom_range(0, 1)),
                   1'b0, no_pin);
        offer_word(MODE_DUMP, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, no_pin);
    endtask

    task automatic drain_run();
        while (shadow_count > 0)
            offer_word(MODE_LOOKUP, shadow_key[$urandom_range(0, shadow_count - 1)],
                       $urandom, 1'($urandom_range(0, 1)), 1'b0, no_pin);
        offer_word(MODE_DUMP, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, no_pin);
    endtask

    task automatic single_op();
        int    r;
        mode_t m;
        r = $urandom_range(0, 19);
        if (r < 8)
            m = MODE_INSERT;
        else if (r < 14)
            m = MODE_LOOKUP;
        else if (r == 14)
            m = MODE_CLEAR;
        else
            m = MODE_DUMP;
        offer_word(m, pick_key(), $urandom, 1'($urandom_range(0, 1)), 1'b0, no_pin);
    endtask

    task automatic plan_add(input mode_t m, input logic [31:0] k,
                            input logic [31:0] p, input logic ins, input int reps,
                            input bit pin, input status_t st,
                            input logic [31:0] ok, input logic [31:0] op);
        plan_row_t row;
        row.mode       = m;
        row.k          = k;
        row.p          = p;
        row.ins        = ins;
        row.reps       = reps;
        row.pin        = pin;
        row.pinned.st  = st;
        row.pinned.k   = ok;
        row.pinned.p   = op;
        row.pinned.lst = 1'b1;
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    hold_count++;
                end
                hold_req = 1'b0;
            end
            stall = snk_idle ? $urandom_range(0, 15) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            status_seen[m_tuser]++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, status %0d key %h payload %h",
                         $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                err_cnt++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (m_tuser !== w.st)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, w.st, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[31:0] !== w.k)
                begin
                    $display("%0t: key expected %h, got %h", $time, w.k, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[63:32] !== w.p)
                begin
                    $display("%0t: payload expected %h, got %h",
                             $time, w.p, m_tdata[63:32]);
                    err_cnt++;
                end
                if (m_tlast !== w.lst)
                begin
                    $display("%0t: last expected %b, got %b", $time, w.lst, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                         $time, idle_cycles, pending_words.size());
                $display("sorted_priority_queue_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int  base;
        int  phase;
        bit  held;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        held     = 1'b0;
        no_pin   = '{ST_INSERTED, 32'h0, 32'h0, 1'b1};
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Empty table, extremes, ties, misses, fill to full, full cases, clears
        plan_add(MODE_DUMP,   32'h0,        32'h0,        1'b0, 1, 1, ST_EMPTY,    '0, '0);
        plan_add(MODE_LOOKUP, 32'h5,        32'h0,        1'b0, 1, 1, ST_NOTFOUND, '0, '0);
        plan_add(MODE_CLEAR,  32'hffffffff, 32'hffffffff, 1'b1, 1, 1, ST_CLEARED,  '0, '0);
        plan_add(MODE_INSERT, 32'h7fffffff, 32'hffffffff, 1'b1, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_INSERT, 32'h80000000, 32'h0,        1'b0, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_INSERT, 32'h0,        32'h1,        1'b0, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_INSERT, 32'h0,        32'h2,        1'b0, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_INSERT, 32'hffffffff, 32'h3,        1'b0, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_LOOKUP, 32'h0,        32'h0,        1'b0, 1, 1, ST_REMOVED,
                 32'h0, 32'h1);
        plan_add(MODE_LOOKUP, 32'h80000000, 32'h0,        1'b0, 1, 1, ST_REMOVED,
                 32'h80000000, 32'h0);
        plan_add(MODE_LOOKUP, 32'h7,        32'h55,       1'b1, 1, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_DUMP,   32'h0,        32'h0,        1'b0, 1, 0, ST_DUMP,     '0, '0);
        plan_add(MODE_INSERT, 32'h3,        32'h100,      1'b0, 12, 1, ST_INSERTED, '0, '0);
        plan_add(MODE_INSERT, 32'h1,        32'h0,        1'b0, 1, 1, ST_FULL,     '0, '0);
        plan_add(MODE_LOOKUP, 32'h64,       32'h0,        1'b1, 1, 1, ST_FULL,     '0, '0);
        plan_add(MODE_DUMP,   32'h0,        32'h0,        1'b1, 1, 0, ST_DUMP,     '0, '0);
        plan_add(MODE_LOOKUP, 32'h3,        32'h0,        1'b0, 1, 1, ST_REMOVED,
                 32'h3, 32'h100);
        plan_add(MODE_CLEAR,  32'h0,        32'h0,        1'b0, 1, 1, ST_CLEARED,  '0, '0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows; repeated rows bump the payload to show arrival order
        foreach (plan[i])
            for (int r = 0; r < plan[i].reps; r++)
                offer_word(plan[i].mode, plan[i].k, plan[i].p + r, plan[i].ins,
                           plan[i].pin, plan[i].pinned);

        // Random runs, rotating idling through both, none, input only, output only
        base = n_items;
        while (n_items - base < RAND_ITEMS)
        begin
            phase    = ((n_items - base) / 30) % 4;
            src_idle = (phase == 0) || (phase == 2);
            snk_idle = (phase == 0) || (phase == 3);
            if (!held && n_items - base >= 60)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
                fill_run();
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: single_op();
                    6, 7:             fill_run();
                    default:          drain_run();
                endcase
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input words, %0d result words checked, %0d output hold-off cycles",
                 n_items, n_results, hold_count);
        $display("seen: %0d inserted, %0d removed, %0d missed, %0d full, %0d dump words",
                 status_seen[ST_INSERTED], status_seen[ST_REMOVED],
                 status_seen[ST_NOTFOUND], status_seen[ST_FULL], status_seen[ST_DUMP]);
        if (err_cnt == 0)
            $display("sorted_priority_queue_unit_tb: done, clean");
        else
            $display("sorted_priority_queue_unit_tb: done, errors");
        $finish;
    end

endmodule
